// ----- rtl/msi_snooping_cache_controller_top_macros.svh -----
// ============================================================================
// MSI snooping cache controller assertion macros
// Shared assertion wrappers that can be compiled out with NO_ASSERTIONS.
// ============================================================================
`ifndef MSI_SNOOPING_CACHE_CONTROLLER_TOP_MACROS_SVH
`define MSI_SNOOPING_CACHE_CONTROLLER_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
`define MSC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("msc assertion failed");
`define MSC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("msc assertion failed");
`else
`define MSC_ASSERT_SAME(label, ante, cons)
`define MSC_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ----- rtl/msc_pkg.sv -----
// ============================================================================
// MSI snooping cache controller package
// Codes, default sizes and shared types of the cache controller.
// ============================================================================
package msc_pkg;

  localparam int unsigned NumSlotsDef  = 2;
  localparam int unsigned AddrWidthDef = 32;
  localparam int unsigned DataWidthDef = 32;
  localparam int unsigned KindW        = 3;
  localparam int unsigned ActionW      = 4;
  localparam int unsigned DigitW       = 4;

  typedef enum logic [1:0] {
    ST_MOD   = 2'd0,
    ST_SHR   = 2'd1,
    ST_INV   = 2'd2,
    ST_EMPTY = 2'd3
  } slot_state_e;

  typedef enum logic [KindW-1:0] {
    KIND_CPU_RD      = 3'd0,
    KIND_CPU_WR      = 3'd1,
    KIND_FILL_SHR    = 3'd2,
    KIND_FILL_MOD    = 3'd3,
    KIND_BUS_INVAL   = 3'd4,
    KIND_BUS_DOWNGRD = 3'd5
  } kind_e;

  typedef enum logic [ActionW-1:0] {
    ACT_RDMISS      = 4'd0,
    ACT_WRMISS      = 4'd1,
    ACT_INVREQ      = 4'd2,
    ACT_WB          = 4'd3,
    ACT_WRHIT       = 4'd4,
    ACT_RDHIT       = 4'd5,
    ACT_UPDATED     = 4'd6,
    ACT_CREATED     = 4'd7,
    ACT_INVALIDATED = 4'd8,
    ACT_SHARED      = 4'd9,
    ACT_ERROR       = 4'd10
  } action_e;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctrl_t;

endpackage

// ----- rtl/msc_if.sv -----
// ============================================================================
// MSI snooping cache controller channels
// Valid/ready channels for request items and result items.
// ============================================================================
interface msc_in_if import msc_pkg::*; #(
  parameter int unsigned ADDR_WIDTH = AddrWidthDef,
  parameter int unsigned DATA_WIDTH = DataWidthDef
);
  logic                  valid;
  logic                  ready;
  logic [KindW-1:0]      kind;
  logic [ADDR_WIDTH-1:0] address;
  logic [DATA_WIDTH-1:0] data;

  modport source (output valid, output kind, output address, output data, input ready);
  modport sink   (input valid, input kind, input address, input data, output ready);
endinterface

interface msc_out_if import msc_pkg::*; #(
  parameter int unsigned ADDR_WIDTH = AddrWidthDef,
  parameter int unsigned DATA_WIDTH = DataWidthDef
);
  logic                  valid;
  logic                  ready;
  logic [ActionW-1:0]    action;
  logic [ADDR_WIDTH-1:0] out_address;
  logic [DATA_WIDTH-1:0] out_data;

  modport source (output valid, output action, output out_address, output out_data,
                  input ready);
  modport sink   (input valid, input action, input out_address, input out_data,
                  output ready);
endinterface

// ----- rtl/msc_residue.sv -----
// ============================================================================
// MSI snooping cache controller slot index unit
// Reduces a block address modulo the slot count from per-digit residues.
// ============================================================================
module msc_residue import msc_pkg::*; #(
  parameter int unsigned NUM_SLOTS  = NumSlotsDef,
  parameter int unsigned ADDR_WIDTH = AddrWidthDef,
  parameter int unsigned IDX_W      = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [ADDR_WIDTH-1:0] addr_i,
  output logic                  done_o,
  output logic [IDX_W-1:0]      idx_o
);

  localparam int unsigned NumDig  = (ADDR_WIDTH + DigitW - 1) / DigitW;
  localparam int unsigned AddrPad = NumDig * DigitW;
  localparam int unsigned DigVals = 2 ** DigitW;
  localparam int unsigned MaxSum  = NumDig * (NUM_SLOTS - 1);
  localparam int unsigned SumW    = $clog2(MaxSum + 1) + 1;

  logic [AddrPad-1:0] addr_pad;
  logic [IDX_W-1:0]   part_d [NumDig];
  logic [IDX_W-1:0]   part_q [NumDig];
  logic [SumW-1:0]    sum;
  logic [IDX_W-1:0]   rem;
  logic [IDX_W-1:0]   idx_q;
  logic               run_q;
  logic               done_q;

  // Weight of hex digit pos, that is 16 to the power pos, modulo the slot count.
  function automatic int unsigned digit_weight(int unsigned pos);
    int unsigned w;
    w = 1 % NUM_SLOTS;
    for (int unsigned k = 0; k < pos; k++) begin
      w = (w * DigVals) % NUM_SLOTS;
    end
    return w;
  endfunction

  assign addr_pad = AddrPad'(addr_i);

  // Each digit selects its residue from a small constant table.
  always_comb begin
    for (int unsigned i = 0; i < NumDig; i++) begin
      part_d[i] = '0;
      for (int unsigned d = 0; d < DigVals; d++) begin
        if (addr_pad[i*DigitW +: DigitW] == DigitW'(d)) begin
          part_d[i] = IDX_W'((d * digit_weight(i)) % NUM_SLOTS);
        end
      end
    end
  end

  // The residues are summed and the small sum is folded by a constant table.
  always_comb begin
    sum = '0;
    for (int unsigned i = 0; i < NumDig; i++) begin
      sum = sum + SumW'(part_q[i]);
    end
    rem = '0;
    for (int unsigned v = 0; v <= MaxSum; v++) begin
      if (sum == SumW'(v)) begin
        rem = IDX_W'(v % NUM_SLOTS);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      part_q <= '{default: '0};
      idx_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else if (start_i) begin
      part_q <= part_d;
      run_q  <= 1'b1;
      done_q <= 1'b0;
    end else if (run_q) begin
      idx_q  <= rem;
      run_q  <= 1'b0;
      done_q <= 1'b1;
    end
  end

  assign done_o = done_q;
  assign idx_o  = idx_q;

endmodule

// ----- rtl/msc_store.sv -----
// ============================================================================
// MSI snooping cache controller slot store
// Synchronous slot memory holding state, address and data of each slot.
// ============================================================================
module msc_store import msc_pkg::*; #(
  parameter int unsigned NUM_SLOTS  = NumSlotsDef,
  parameter int unsigned ADDR_WIDTH = AddrWidthDef,
  parameter int unsigned DATA_WIDTH = DataWidthDef,
  parameter int unsigned IDX_W      = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  mem_ctrl_t             ctrl_i,
  input  logic [IDX_W-1:0]      idx_i,
  input  slot_state_e           wr_state_i,
  input  logic [ADDR_WIDTH-1:0] wr_addr_i,
  input  logic [DATA_WIDTH-1:0] wr_data_i,
  output slot_state_e           rd_state_o,
  output logic [ADDR_WIDTH-1:0] rd_addr_o,
  output logic [DATA_WIDTH-1:0] rd_data_o
);

  localparam int unsigned EntryW = 2 + ADDR_WIDTH + DATA_WIDTH;

  logic [EntryW-1:0]    mem_q [NUM_SLOTS];
  logic [EntryW-1:0]    rd_q;
  logic [NUM_SLOTS-1:0] vld_q;
  logic                 rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      mem_q[idx_i] <= {wr_state_i, wr_addr_i, wr_data_i};
    end
    if (ctrl_i.rd_en) begin
      rd_q <= mem_q[idx_i];
    end
  end

  // A slot never written since reset reads as empty with zero address and data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (ctrl_i.wr_en) begin
        vld_q[idx_i] <= 1'b1;
      end
      if (ctrl_i.rd_en) begin
        rd_vld_q <= vld_q[idx_i];
      end
    end
  end

  assign rd_state_o = rd_vld_q ? slot_state_e'(rd_q[EntryW-1 -: 2]) : ST_EMPTY;
  assign rd_addr_o  = rd_vld_q ? rd_q[DATA_WIDTH +: ADDR_WIDTH] : '0;
  assign rd_data_o  = rd_vld_q ? rd_q[DATA_WIDTH-1:0] : '0;

endmodule

// ----- rtl/msc_seq.sv -----
// ============================================================================
// MSI snooping cache controller sequencer
// Steps one item through slot reads, coherence decisions and write-back.
// ============================================================================
module msc_seq import msc_pkg::*; #(
  parameter int unsigned NUM_SLOTS  = NumSlotsDef,
  parameter int unsigned ADDR_WIDTH = AddrWidthDef,
  parameter int unsigned DATA_WIDTH = DataWidthDef,
  parameter int unsigned IDX_W      = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  msc_in_if.sink                in_i,
  msc_out_if.source             out_o,
  output logic                  res_start_o,
  output logic [ADDR_WIDTH-1:0] res_addr_o,
  input  logic                  res_done_i,
  input  logic [IDX_W-1:0]      res_idx_i,
  output mem_ctrl_t             mem_ctrl_o,
  output logic [IDX_W-1:0]      mem_idx_o,
  output slot_state_e           mem_wr_state_o,
  output logic [ADDR_WIDTH-1:0] mem_wr_addr_o,
  output logic [DATA_WIDTH-1:0] mem_wr_data_o,
  input  slot_state_e           mem_rd_state_i,
  input  logic [ADDR_WIDTH-1:0] mem_rd_addr_i,
  input  logic [DATA_WIDTH-1:0] mem_rd_data_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RES,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_MAP_RD,
    S_MAP_CHK,
    S_EMIT
  } seq_state_e;

  localparam logic [IDX_W-1:0] LastIdx = IDX_W'(NUM_SLOTS - 1);

  seq_state_e            st_q;
  kind_e                 kind_q;
  logic [ADDR_WIDTH-1:0] addr_q;
  logic [DATA_WIDTH-1:0] data_q;
  logic [IDX_W-1:0]      idx_q;
  action_e               pact_q;
  logic [ADDR_WIDTH-1:0] paddr_q;
  logic [DATA_WIDTH-1:0] pdata_q;
  logic                  ov_q;
  action_e               act_q;
  logic [ADDR_WIDTH-1:0] oaddr_q;
  logic [DATA_WIDTH-1:0] odata_q;
  logic                  hit;
  logic                  is_wr;
  action_e               miss_act;
  logic                  emit_go;

  assign hit      = (mem_rd_state_i != ST_EMPTY) && (mem_rd_addr_i == addr_q);
  assign is_wr    = (kind_q == KIND_CPU_WR);
  assign miss_act = is_wr ? ACT_WRMISS : ACT_RDMISS;
  assign emit_go  = (st_q == S_EMIT) && (!ov_q || out_o.ready);

  assign in_i.ready  = (st_q == S_IDLE);
  assign res_start_o = in_i.valid && (st_q == S_IDLE);
  assign res_addr_o  = in_i.address;

  always_comb begin
    mem_ctrl_o.rd_en = (st_q == S_SCAN_RD) || (st_q == S_MAP_RD);
    mem_ctrl_o.wr_en = 1'b0;
    mem_idx_o        = ((st_q == S_SCAN_RD) || (st_q == S_SCAN_CHK)) ? idx_q : res_idx_i;
    mem_wr_state_o   = mem_rd_state_i;
    mem_wr_addr_o    = mem_rd_addr_i;
    mem_wr_data_o    = mem_rd_data_i;
    if (st_q == S_SCAN_CHK) begin
      mem_ctrl_o.wr_en = hit && (mem_rd_state_i == ST_MOD) && is_wr;
      mem_wr_data_o    = data_q;
    end else if (st_q == S_MAP_CHK) begin
      unique case (kind_q)
        KIND_FILL_SHR, KIND_FILL_MOD: begin
          mem_ctrl_o.wr_en = 1'b1;
          mem_wr_state_o   = (kind_q == KIND_FILL_SHR) ? ST_SHR : ST_MOD;
          mem_wr_addr_o    = addr_q;
          mem_wr_data_o    = data_q;
        end
        KIND_BUS_INVAL: begin
          mem_ctrl_o.wr_en = 1'b1;
          mem_wr_state_o   = ST_INV;
        end
        KIND_BUS_DOWNGRD: begin
          mem_ctrl_o.wr_en = 1'b1;
          mem_wr_state_o   = ST_SHR;
        end
        default: begin
          mem_ctrl_o.wr_en = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= S_IDLE;
      kind_q  <= KIND_CPU_RD;
      addr_q  <= '0;
      data_q  <= '0;
      idx_q   <= '0;
      pact_q  <= ACT_ERROR;
      paddr_q <= '0;
      pdata_q <= '0;
      ov_q    <= 1'b0;
      act_q   <= ACT_ERROR;
      oaddr_q <= '0;
      odata_q <= '0;
    end else begin
      if (emit_go) begin
        ov_q <= 1'b1;
      end else if (out_o.ready) begin
        ov_q <= 1'b0;
      end
      unique case (st_q)
        S_IDLE: begin
          if (in_i.valid) begin
            kind_q <= kind_e'(in_i.kind);
            addr_q <= in_i.address;
            data_q <= in_i.data;
            st_q   <= S_RES;
          end
        end
        S_RES: begin
          if (res_done_i) begin
            unique case (kind_q)
              KIND_CPU_RD, KIND_CPU_WR: begin
                idx_q <= '0;
                st_q  <= S_SCAN_RD;
              end
              KIND_FILL_SHR, KIND_FILL_MOD, KIND_BUS_INVAL, KIND_BUS_DOWNGRD: begin
                st_q <= S_MAP_RD;
              end
              default: begin
                pact_q  <= ACT_ERROR;
                paddr_q <= addr_q;
                pdata_q <= '0;
                st_q    <= S_EMIT;
              end
            endcase
          end
        end
        S_SCAN_RD: begin
          st_q <= S_SCAN_CHK;
        end
        S_SCAN_CHK: begin
          if (hit) begin
            paddr_q <= addr_q;
            st_q    <= S_EMIT;
            unique case (mem_rd_state_i)
              ST_MOD: begin
                pact_q  <= is_wr ? ACT_WRHIT : ACT_RDHIT;
                pdata_q <= is_wr ? data_q : mem_rd_data_i;
              end
              ST_SHR: begin
                pact_q  <= is_wr ? ACT_INVREQ : ACT_RDHIT;
                pdata_q <= is_wr ? '0 : mem_rd_data_i;
              end
              default: begin
                pact_q  <= miss_act;
                pdata_q <= '0;
              end
            endcase
          end else if (idx_q == LastIdx) begin
            st_q <= S_MAP_RD;
          end else begin
            idx_q <= idx_q + IDX_W'(1);
            st_q  <= S_SCAN_RD;
          end
        end
        S_MAP_RD: begin
          st_q <= S_MAP_CHK;
        end
        S_MAP_CHK: begin
          st_q <= S_EMIT;
          unique case (kind_q)
            KIND_FILL_SHR, KIND_FILL_MOD: begin
              pact_q  <= (mem_rd_addr_i == addr_q) ? ACT_UPDATED : ACT_CREATED;
              paddr_q <= addr_q;
              pdata_q <= data_q;
            end
            KIND_BUS_INVAL: begin
              pact_q  <= ACT_INVALIDATED;
              paddr_q <= mem_rd_addr_i;
              pdata_q <= mem_rd_data_i;
            end
            KIND_BUS_DOWNGRD: begin
              pact_q  <= ACT_SHARED;
              paddr_q <= mem_rd_addr_i;
              pdata_q <= mem_rd_data_i;
            end
            default: begin
              if (mem_rd_state_i == ST_MOD) begin
                pact_q  <= ACT_WB;
                paddr_q <= mem_rd_addr_i;
                pdata_q <= mem_rd_data_i;
              end else begin
                pact_q  <= miss_act;
                paddr_q <= addr_q;
                pdata_q <= '0;
              end
            end
          endcase
        end
        S_EMIT: begin
          if (emit_go) begin
            act_q   <= pact_q;
            oaddr_q <= paddr_q;
            odata_q <= pdata_q;
            st_q    <= S_IDLE;
          end
        end
        default: begin
          st_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_o.valid       = ov_q;
  assign out_o.action      = act_q;
  assign out_o.out_address = oaddr_q;
  assign out_o.out_data    = odata_q;

endmodule

// ----- rtl/msi_snooping_cache_controller_top.sv -----
// ============================================================================
// MSI snooping cache controller
// Small coherent L1 cache that answers processor accesses and bus messages.
// ============================================================================
// The controller takes one item at a time and returns exactly one result for it
// through an output register, so a new item can be taken while the previous
// result still waits. The slots live in one synchronous memory with a single
// port; every slot access goes through a read state and a check state, and the
// mapped slot index is built from constant residues of the address digits.
// The input is ready again in the cycle after the result is registered; a result
// that is not taken holds the next item in its last cycle.
module msi_snooping_cache_controller_top import msc_pkg::*; #(
  parameter int unsigned NUM_SLOTS  = NumSlotsDef,
  parameter int unsigned ADDR_WIDTH = AddrWidthDef,
  parameter int unsigned DATA_WIDTH = DataWidthDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  msc_in_if.sink    in_i,
  msc_out_if.source out_o
);

  `include "msi_snooping_cache_controller_top_macros.svh"

  localparam int unsigned IdxW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  logic                  res_start;
  logic [ADDR_WIDTH-1:0] res_addr;
  logic                  res_done;
  logic [IdxW-1:0]       res_idx;
  mem_ctrl_t             mem_ctrl;
  logic [IdxW-1:0]       mem_idx;
  slot_state_e           mem_wr_state;
  logic [ADDR_WIDTH-1:0] mem_wr_addr;
  logic [DATA_WIDTH-1:0] mem_wr_data;
  slot_state_e           mem_rd_state;
  logic [ADDR_WIDTH-1:0] mem_rd_addr;
  logic [DATA_WIDTH-1:0] mem_rd_data;

  msc_residue #(
    .NUM_SLOTS (NUM_SLOTS),
    .ADDR_WIDTH(ADDR_WIDTH),
    .IDX_W     (IdxW)
  ) u_residue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(res_start),
    .addr_i (res_addr),
    .done_o (res_done),
    .idx_o  (res_idx)
  );

  msc_store #(
    .NUM_SLOTS (NUM_SLOTS),
    .ADDR_WIDTH(ADDR_WIDTH),
    .DATA_WIDTH(DATA_WIDTH),
    .IDX_W     (IdxW)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (mem_ctrl),
    .idx_i     (mem_idx),
    .wr_state_i(mem_wr_state),
    .wr_addr_i (mem_wr_addr),
    .wr_data_i (mem_wr_data),
    .rd_state_o(mem_rd_state),
    .rd_addr_o (mem_rd_addr),
    .rd_data_o (mem_rd_data)
  );

  msc_seq #(
    .NUM_SLOTS (NUM_SLOTS),
    .ADDR_WIDTH(ADDR_WIDTH),
    .DATA_WIDTH(DATA_WIDTH),
    .IDX_W     (IdxW)
  ) u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_i          (in_i),
    .out_o         (out_o),
    .res_start_o   (res_start),
    .res_addr_o    (res_addr),
    .res_done_i    (res_done),
    .res_idx_i     (res_idx),
    .mem_ctrl_o    (mem_ctrl),
    .mem_idx_o     (mem_idx),
    .mem_wr_state_o(mem_wr_state),
    .mem_wr_addr_o (mem_wr_addr),
    .mem_wr_data_o (mem_wr_data),
    .mem_rd_state_i(mem_rd_state),
    .mem_rd_addr_i (mem_rd_addr),
    .mem_rd_data_i (mem_rd_data)
  );

  `MSC_ASSERT_NEXT(a_busy_after_transfer, in_i.valid && in_i.ready, !in_i.ready)
  `MSC_ASSERT_SAME(a_no_rd_wr_overlap, mem_ctrl.wr_en, !mem_ctrl.rd_en)
  `MSC_ASSERT_SAME(a_write_only_in_work, mem_ctrl.wr_en, !in_i.ready)
  `MSC_ASSERT_SAME(a_index_in_range, res_done, res_idx <= IdxW'(NUM_SLOTS - 1))

endmodule

// ----- tb/msc_coherence_checker.sv -----
`timescale 1ns / 1ps
// ============================================================================
// MSI cache coherence checker
// Watches the request and result channels of the cache controller. Each
// request transfer updates a private copy of the slots and queues the
// expected result. Each result transfer is compared field by field with the
// oldest expected result.
// ============================================================================
module msc_coherence_checker import msc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  msc_in_if           req_mon,
  msc_out_if          rsp_mon,
  output int unsigned pending_o,
  output int unsigned mismatch_o
);

  typedef struct packed {
    logic [ActionW-1:0]      action;
    logic [AddrWidthDef-1:0] address;
    logic [DataWidthDef-1:0] data;
  } cache_result_t;

  logic [AddrWidthDef-1:0] line_addr  [NumSlotsDef];
  logic [DataWidthDef-1:0] line_data  [NumSlotsDef];
  slot_state_e             line_state [NumSlotsDef];

  cache_result_t result_q [$];
  cache_result_t want;
  cache_result_t got;
  int unsigned   mismatch_cnt;

  function automatic cache_result_t pack_result(action_e act, logic [AddrWidthDef-1:0] addr,
                                                logic [DataWidthDef-1:0] data);
    cache_result_t res;
    res.action  = act;
    res.address = addr;
    res.data    = data;
    return res;
  endfunction

  function automatic cache_result_t coherence_step(logic [KindW-1:0] kind,
                                                   logic [AddrWidthDef-1:0] addr,
                                                   logic [DataWidthDef-1:0] data);
    int unsigned   idx;
    int unsigned   hit;
    bit            found;
    bit            is_wr;
    action_e       act;
    cache_result_t res;
    idx   = addr % NumSlotsDef;
    hit   = 0;
    found = 1'b0;
    is_wr = (kind == KIND_CPU_WR);
    case (kind)
      KIND_CPU_RD, KIND_CPU_WR: begin
        for (int k = 0; k < NumSlotsDef; k++) begin
          if (!found && line_state[k] != ST_EMPTY && line_addr[k] == addr) begin
            hit   = k;
            found = 1'b1;
          end
        end
        if (found) begin
          case (line_state[hit])
            ST_MOD: begin
              if (is_wr) begin
                line_data[hit] = data;
                res = pack_result(ACT_WRHIT, addr, data);
              end else begin
                res = pack_result(ACT_RDHIT, addr, line_data[hit]);
              end
            end
            ST_SHR: begin
              if (is_wr) res = pack_result(ACT_INVREQ, addr, '0);
              else res = pack_result(ACT_RDHIT, addr, line_data[hit]);
            end
            default: begin
              res = pack_result(is_wr ? ACT_WRMISS : ACT_RDMISS, addr, '0);
            end
          endcase
        end else if (line_state[idx] == ST_MOD) begin
          res = pack_result(ACT_WB, line_addr[idx], line_data[idx]);
        end else begin
          res = pack_result(is_wr ? ACT_WRMISS : ACT_RDMISS, addr, '0);
        end
      end
      KIND_FILL_SHR, KIND_FILL_MOD: begin
        act              = (line_addr[idx] == addr) ? ACT_UPDATED : ACT_CREATED;
        line_addr[idx]   = addr;
        line_data[idx]   = data;
        line_state[idx]  = (kind == KIND_FILL_SHR) ? ST_SHR : ST_MOD;
        res = pack_result(act, addr, data);
      end
      KIND_BUS_INVAL: begin
        line_state[idx] = ST_INV;
        res = pack_result(ACT_INVALIDATED, line_addr[idx], line_data[idx]);
      end
      KIND_BUS_DOWNGRD: begin
        line_state[idx] = ST_SHR;
        res = pack_result(ACT_SHARED, line_addr[idx], line_data[idx]);
      end
      default: begin
        res = pack_result(ACT_ERROR, addr, '0);
      end
    endcase
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NumSlotsDef; k++) begin
        line_addr[k]  = '0;
        line_data[k]  = '0;
        line_state[k] = ST_EMPTY;
      end
      result_q.delete();
      mismatch_cnt = 0;
      pending_o  <= 0;
      mismatch_o <= 0;
    end else begin
      if (rsp_mon.valid && rsp_mon.ready) begin
        got.action  = rsp_mon.action;
        got.address = rsp_mon.out_address;
        got.data    = rsp_mon.out_data;
        if (result_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $display("%0t: result with nothing expected: action %0d address %h data %h",
                     $time, got.action, got.address, got.data);
          end
        end else begin
          want = result_q.pop_front();
          if (got.action !== want.action || got.address !== want.address ||
              got.data !== want.data) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10) begin
              $display("%0t: result mismatch: action %0d/%0d address %h/%h data %h/%h",
                       $time, want.action, got.action, want.address, got.address,
                       want.data, got.data);
              $display("  (values given as expected/actual)");
            end
          end
        end
      end
      if (req_mon.valid && req_mon.ready) begin
        result_q.push_back(coherence_step(req_mon.kind, req_mon.address, req_mon.data));
      end
      pending_o  <= result_q.size();
      mismatch_o <= mismatch_cnt;
    end
  end

endmodule

// ----- tb/msi_snooping_cache_controller_top_tb.sv -----
`timescale 1ns / 1ps
// ============================================================================
// MSI snooping cache controller testbench
// Drives a directed sequence through every coherence case and then random
// processor accesses and bus messages over a small address pool, with random
// gaps on the request side and random stalls on the result side. The checker
// beside the controller predicts and compares every result.
// ============================================================================
module msi_snooping_cache_controller_top_tb;
  import msc_pkg::*;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned DrainCycles = 24;
  localparam int unsigned RandomItems = 700;
  localparam int unsigned PoolSize    = 6;

  logic        clk_i     = 1'b0;
  logic        rst_ni    = 1'b0;
  bit          calm      = 1'b0;
  int unsigned cycle_cnt = 0;
  int unsigned pending;
  int unsigned mismatches;

  logic [AddrWidthDef-1:0] addr_pool [PoolSize];

  msc_in_if  req_if ();
  msc_out_if rsp_if ();

  msi_snooping_cache_controller_top u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if),
    .out_o  (rsp_if)
  );

  msc_coherence_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_mon    (req_if),
    .rsp_mon    (rsp_if),
    .pending_o  (pending),
    .mismatch_o (mismatches)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int unsigned hold;
    hold = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold != 0) begin
        rsp_if.ready <= 1'b0;
        hold--;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        rsp_if.ready <= 1'b0;
        hold = $urandom_range(0, 2);
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  task automatic send_request(input logic [KindW-1:0] kind,
                              input logic [AddrWidthDef-1:0] addr,
                              input logic [DataWidthDef-1:0] data);
    req_if.valid   <= 1'b1;
    req_if.kind    <= kind;
    req_if.address <= addr;
    req_if.data    <= data;
    do @(posedge clk_i); while (!req_if.ready);
    if (!calm && $urandom_range(0, 5) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  function automatic logic [KindW-1:0] pick_kind();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 30) return KIND_CPU_RD;
    if (r < 55) return KIND_CPU_WR;
    if (r < 67) return KIND_FILL_SHR;
    if (r < 79) return KIND_FILL_MOD;
    if (r < 87) return KIND_BUS_INVAL;
    if (r < 95) return KIND_BUS_DOWNGRD;
    return KindW'(KIND_BUS_DOWNGRD + $urandom_range(1, 2));
  endfunction

  function automatic logic [AddrWidthDef-1:0] pick_address();
    if ($urandom_range(0, 99) < 85) return addr_pool[$urandom_range(0, PoolSize - 1)];
    return $urandom();
  endfunction

  function automatic logic [DataWidthDef-1:0] pick_data();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 20) return '1;
    return $urandom();
  endfunction

  initial begin
    req_if.valid   <= 1'b0;
    req_if.kind    <= KIND_CPU_RD;
    req_if.address <= '0;
    req_if.data    <= '0;
    addr_pool[0] = '0;
    addr_pool[1] = '1;
    for (int k = 2; k < PoolSize; k++) addr_pool[k] = $urandom();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Slot 0 starts empty with address zero, so the first fill to zero updates it.
    send_request(KIND_CPU_RD,      32'h0000_0000, 32'h1111_1111);
    send_request(KIND_FILL_SHR,    32'h0000_0000, 32'hC0DE_0001);
    send_request(KIND_CPU_RD,      32'h0000_0000, 32'h0000_0000);
    send_request(KIND_CPU_WR,      32'h0000_0000, 32'h2222_2222);
    send_request(KIND_BUS_DOWNGRD, 32'h0000_0001, 32'h0000_0000);
    send_request(KIND_CPU_RD,      32'h0000_0000, 32'h0000_0000);
    send_request(KIND_FILL_MOD,    32'hFFFF_FFFF, 32'hA5A5_A5A5);
    send_request(KIND_CPU_WR,      32'hFFFF_FFFF, 32'h0000_0000);
    send_request(KIND_CPU_RD,      32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(KIND_CPU_RD,      32'h0000_0003, 32'h0000_0000);
    send_request(KIND_CPU_WR,      32'h0000_0003, 32'h3333_3333);
    send_request(KIND_BUS_INVAL,   32'h1234_5677, 32'h0000_0000);
    send_request(KIND_CPU_RD,      32'hFFFF_FFFF, 32'h0000_0000);
    send_request(KIND_CPU_WR,      32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(KIND_BUS_INVAL,   32'h0000_0002, 32'h0000_0000);
    send_request(KIND_BUS_DOWNGRD + 3'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(KIND_BUS_DOWNGRD + 3'd2, 32'h5A5A_5A5A, 32'h1234_5678);
    send_request(KIND_FILL_MOD,    32'h0000_0000, 32'hFFFF_FFFF);
    send_request(KIND_CPU_RD,      32'h0000_0002, 32'h0000_0000);
    send_request(KIND_BUS_DOWNGRD, 32'h0000_0000, 32'h0000_0000);
    send_request(KIND_CPU_WR,      32'h0000_0002, 32'h4444_4444);
    send_request(KIND_FILL_SHR,    32'hAAAA_AAAA, 32'h5555_5555);
    send_request(KIND_CPU_RD,      32'hAAAA_AAAA, 32'h0000_0000);
    send_request(KIND_BUS_DOWNGRD, 32'h5555_5555, 32'h0000_0000);

    for (int unsigned i = 0; i < RandomItems; i++) begin
      if (i % 100 == 0) begin
        for (int k = 2; k < PoolSize; k++) addr_pool[k] = $urandom();
      end
      calm = (i >= 200 && i < 300) || (i >= 600);
      if (i == 350 || i == 500) wait_drained();
      send_request(pick_kind(), pick_address(), pick_data());
    end

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
